// ===== sv/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and constants for the integer literal parser
// Holds the phase, radix and status codes and the character constants used
// by the parser and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ZERO = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    ST_INT       = 2'd0,
    ST_NOT_INT   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  // Marks a character that is no digit in any radix.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LONG_LIMIT = 64'h0000_0000_FFFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/ilp_in_if.sv =====
// ----------------------------------------------------------------------------
// ilp_in_if: character channel of the integer literal parser
// Carries one text byte per beat, or the end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       text_ended;

  modport source (output valid, output char_in, output text_ended, input ready);
  modport sink   (input valid, input char_in, input text_ended, output ready);
endinterface

`default_nettype wire

// ===== sv/ilp_out_if.sv =====
// ----------------------------------------------------------------------------
// ilp_out_if: result channel of the integer literal parser
// Carries one parsed token per beat: status, value, base, flags and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilp_out_if #(
  parameter int LEN_W = 7
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [63:0]      value;
  logic [1:0]       base_code;
  logic             is_long;
  logic [LEN_W-1:0] token_length;
  logic             overflowed;

  modport source (output valid, output status, output value, output base_code,
                  output is_long, output token_length, output overflowed,
                  input ready);
  modport sink   (input valid, input status, input value, input base_code,
                  input is_long, input token_length, input overflowed,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/integer_literal_parser.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parser: streaming C-style integer literal parser
// Takes a token one character per beat and reports decimal, octal, hex or
// binary literals with value, base, long and overflow flags and length.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   in_ch     sink       char_in[7:0], text_ended
//   out_ch    source     status, value[63:0], base_code, is_long,
//                        token_length, overflowed
//
// One character is taken every cycle unless the input side stalls. A beat is
// held in an input register and then updates the parse state; a finished
// token is written to the result register at that same edge and offered from
// there. The input side stalls only when a result is due while the result
// register is still held by the sink. Reset is synchronous and puts the
// parser back to waiting for the first character.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser
  import ilp_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ilp_in_if.sink     in_ch,
  ilp_out_if.source  out_ch
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_ended_r;

  // Parse state
  phase_t           phase_r,     phase_nxt;
  radix_t           radix_r,     radix_nxt;
  logic [63:0]      acc_r,       acc_nxt;
  logic             ovf_r,       ovf_nxt;
  logic             mal_r,       mal_nxt;
  logic [LEN_W-1:0] count_r,     count_nxt;

  // Result register
  logic             out_valid_r;
  status_t          res_status_r, res_status_nxt;
  logic [63:0]      res_value_r;
  radix_t           res_base_r;
  logic             res_long_r;
  logic [LEN_W-1:0] res_len_r;
  logic             res_ovf_r;

  logic        emit;
  logic        out_free;
  logic        s1_go;
  logic        in_fire;
  logic        is_dec;
  logic        is_alnum;
  logic        term;
  logic [4:0]  digit;
  logic        digit_ok;
  logic [3:0]  digit_lim;
  logic [67:0] dec_sum;
  logic [LEN_W-1:0] count_inc;
  logic        res_ok;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Character classes
  always_comb begin
    is_dec   = (s1_char_r >= CH_0) && (s1_char_r <= CH_9);
    is_alnum = is_dec ||
               ((s1_char_r >= CH_LO_A) && (s1_char_r <= CH_LO_Z)) ||
               ((s1_char_r >= CH_UP_A) && (s1_char_r <= CH_UP_Z));
    term     = s1_ended_r || !is_alnum;

    if (is_dec) begin
      digit = 5'(s1_char_r - CH_0);
    end else if ((s1_char_r >= CH_LO_A) && (s1_char_r <= CH_LO_F)) begin
      digit = 5'(s1_char_r - CH_LO_A) + 5'd10;
    end else if ((s1_char_r >= CH_UP_A) && (s1_char_r <= CH_UP_F)) begin
      digit = 5'(s1_char_r - CH_UP_A) + 5'd10;
    end else begin
      digit = DIGIT_NONE;
    end

    unique case (radix_r)
      RADIX_BIN: digit_lim = 4'd1;
      RADIX_OCT: digit_lim = 4'd7;
      RADIX_DEC: digit_lim = 4'd9;
      RADIX_HEX: digit_lim = 4'd15;
      default:   digit_lim = 4'd15;
    endcase
    digit_ok = (digit != DIGIT_NONE) && (digit[3:0] <= digit_lim);

    // a * 10 + d; anything above bit 63 means the value no longer fits.
    dec_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {63'd0, digit};

    count_inc = (count_r < LEN_W'(MAX_TOKEN_LEN)) ? count_r + 1'b1 : count_r;
  end

  // Parse step
  always_comb begin
    phase_nxt      = phase_r;
    radix_nxt      = radix_r;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    mal_nxt        = mal_r;
    count_nxt      = count_r;
    emit           = 1'b0;
    res_status_nxt = ST_INT;

    unique case (phase_r)
      PH_IDLE: begin
        if (s1_ended_r || !is_dec) begin
          emit           = 1'b1;
          res_status_nxt = ST_NOT_INT;
        end else begin
          count_nxt = count_inc;
          if (s1_char_r == CH_0) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = PH_RUN;
            radix_nxt = RADIX_DEC;
            acc_nxt   = {60'd0, digit[3:0]};
          end
        end
      end
      PH_ZERO: begin
        if (term) begin
          emit = 1'b1;
        end else begin
          count_nxt = count_inc;
          phase_nxt = PH_RUN;
          if (s1_char_r == CH_LO_X) begin
            radix_nxt = RADIX_HEX;
          end else if (s1_char_r == CH_LO_B || s1_char_r == CH_UP_B) begin
            radix_nxt = RADIX_BIN;
          end else if (s1_char_r >= CH_0 && s1_char_r <= CH_7) begin
            radix_nxt = RADIX_OCT;
            acc_nxt   = {61'd0, digit[2:0]};
          end else begin
            mal_nxt = 1'b1;
          end
        end
      end
      PH_RUN: begin
        if (term) begin
          emit = 1'b1;
        end else begin
          count_nxt = count_inc;
          if (!mal_r) begin
            if (!digit_ok) begin
              mal_nxt = 1'b1;
            end else begin
              case (radix_r)
                RADIX_BIN: begin
                  ovf_nxt = ovf_r | acc_r[63];
                  acc_nxt = {acc_r[62:0], digit[0]};
                end
                RADIX_OCT: begin
                  if (acc_r[63:61] != 3'd0) begin
                    ovf_nxt = 1'b1;
                    acc_nxt = ALL_ONES;
                  end else begin
                    acc_nxt = {acc_r[60:0], digit[2:0]};
                  end
                end
                RADIX_HEX: begin
                  if (acc_r[63:60] != 4'd0) begin
                    ovf_nxt = 1'b1;
                    acc_nxt = ALL_ONES;
                  end else begin
                    acc_nxt = {acc_r[59:0], digit[3:0]};
                  end
                end
                default: begin
                  if (dec_sum[67:64] != 4'd0) begin
                    ovf_nxt = 1'b1;
                    acc_nxt = ALL_ONES;
                  end else begin
                    acc_nxt = dec_sum[63:0];
                  end
                end
              endcase
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // A finished token reports how it ended; a dot means a float follows.
    if (emit && phase_r != PH_IDLE) begin
      if (mal_r) begin
        res_status_nxt = ST_MALFORMED;
      end else if (!s1_ended_r && s1_char_r == CH_DOT) begin
        res_status_nxt = ST_NOT_INT;
      end else begin
        res_status_nxt = ST_INT;
      end
    end

    // Emitting a token returns the parser to its reset state.
    if (emit) begin
      phase_nxt = PH_IDLE;
      radix_nxt = RADIX_DEC;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      mal_nxt   = 1'b0;
      count_nxt = '0;
    end
  end

  assign res_ok = (res_status_nxt == ST_INT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r  <= in_ch.char_in;
      s1_ended_r <= in_ch.text_ended;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      radix_r <= RADIX_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      mal_r   <= 1'b0;
      count_r <= '0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      mal_r   <= mal_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      res_status_r <= res_status_nxt;
      res_value_r  <= res_ok ? acc_r : 64'd0;
      res_base_r   <= radix_r;
      res_long_r   <= res_ok && (acc_r >= LONG_LIMIT);
      res_len_r    <= count_r;
      res_ovf_r    <= res_ok && ovf_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_status_r;
  assign out_ch.value        = res_value_r;
  assign out_ch.base_code    = res_base_r;
  assign out_ch.is_long      = res_long_r;
  assign out_ch.token_length = res_len_r;
  assign out_ch.overflowed   = res_ovf_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer literal parser
// Streams tokens into the parser one character per beat and checks every
// result against a cycle-free model of the same parse, kept in the bench.
// A short directed set covers each literal form and its corner cases; the
// random part mostly builds well-formed numbers with random digits, and
// mixes in junk, boundary values and long runs. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import ilp_pkg::*;

  localparam int TOKEN_LEN_MAX = 64;
  localparam int LEN_W         = $clog2(TOKEN_LEN_MAX + 1);
  localparam int RANDOM_CHARS  = 1100;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef struct packed {
    status_t          status;
    logic [63:0]      value;
    radix_t           base_code;
    logic             is_long;
    logic [LEN_W-1:0] token_length;
    logic             overflowed;
  } token_result_t;

  logic clk;
  logic rst_n;

  ilp_in_if in_if ();
  ilp_out_if #(.LEN_W(LEN_W)) out_if ();

  integer_literal_parser #(
    .MAX_TOKEN_LEN(TOKEN_LEN_MAX)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Bench copy of the parse state.
  phase_t           lit_phase;
  radix_t           lit_radix;
  logic [63:0]      lit_value;
  bit               lit_overflow;
  bit               lit_malformed;
  logic [LEN_W-1:0] lit_length;

  token_result_t expected_tokens[$];

  int chars_sent       = 0;
  int checked_tokens   = 0;
  int int_tokens       = 0;
  int malformed_tokens = 0;
  int overflow_tokens  = 0;
  int failures         = 0;
  int cycle_count      = 0;
  bit steady_flow      = 1'b0;

  string boundary_literals[8] = '{
    "18446744073709551615", "18446744073709551616",
    "4294967295", "4294967294",
    "0xffffffffffffffff", "0x10000000000000000",
    "01777777777777777777777", "02000000000000000000000"
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic int max_digit(radix_t r);
    case (r)
      RADIX_BIN: return 1;
      RADIX_OCT: return 7;
      RADIX_DEC: return 9;
      default:   return 15;
    endcase
  endfunction

  // Digit value in the given radix, or -1 where the character is no digit of it.
  function automatic int digit_value(logic [7:0] c, radix_t r);
    int d;
    d = -1;
    if (is_digit(c)) d = int'(c) - int'(CH_0);
    else if (c >= CH_LO_A && c <= CH_LO_F) d = int'(c) - int'(CH_LO_A) + 10;
    else if (c >= CH_UP_A && c <= CH_UP_F) d = int'(c) - int'(CH_UP_A) + 10;
    if (d > max_digit(r)) d = -1;
    return d;
  endfunction

  function void clear_literal();
    lit_phase     = PH_IDLE;
    lit_radix     = RADIX_DEC;
    lit_value     = '0;
    lit_overflow  = 1'b0;
    lit_malformed = 1'b0;
    lit_length    = '0;
  endfunction

  function token_result_t close_literal(status_t st);
    token_result_t r;
    bit ok;
    ok             = (st == ST_INT);
    r.status       = st;
    r.value        = ok ? lit_value : '0;
    r.base_code    = lit_radix;
    r.is_long      = ok && (lit_value >= LONG_LIMIT);
    r.token_length = lit_length;
    r.overflowed   = ok && lit_overflow;
    clear_literal();
    return r;
  endfunction

  // Decimal, octal and hex saturate on overflow; binary simply wraps.
  function void add_digit(int d);
    logic [63:0] dv;
    dv = 64'(d);
    case (lit_radix)
      RADIX_BIN: begin
        if (lit_value[63]) lit_overflow = 1'b1;
        lit_value = {lit_value[62:0], dv[0]};
      end
      RADIX_OCT: begin
        if (lit_value[63:61] != 3'b000) begin
          lit_overflow = 1'b1;
          lit_value    = ALL_ONES;
        end else begin
          lit_value = {lit_value[60:0], dv[2:0]};
        end
      end
      RADIX_HEX: begin
        if (lit_value[63:60] != 4'h0) begin
          lit_overflow = 1'b1;
          lit_value    = ALL_ONES;
        end else begin
          lit_value = {lit_value[59:0], dv[3:0]};
        end
      end
      default: begin
        if (lit_value > (ALL_ONES - dv) / 64'd10) begin
          lit_overflow = 1'b1;
          lit_value    = ALL_ONES;
        end else begin
          lit_value = lit_value * 64'd10 + dv;
        end
      end
    endcase
  endfunction

  function void count_char();
    if (lit_length < TOKEN_LEN_MAX) lit_length++;
  endfunction

  // Applies one accepted beat to the model and queues any result it closes.
  function void advance_literal(logic [7:0] c, bit ended);
    bit      term;
    status_t st;
    int      d;
    term = ended || !is_alnum(c);
    if (lit_phase == PH_IDLE) begin
      if (ended || !is_digit(c)) begin
        expected_tokens.push_back(close_literal(ST_NOT_INT));
        return;
      end
      count_char();
      if (c == CH_0) begin
        lit_phase = PH_ZERO;
      end else begin
        lit_phase = PH_RUN;
        lit_radix = RADIX_DEC;
        lit_value = 64'(c - CH_0);
      end
      return;
    end
    if (term) begin
      if (lit_malformed) st = ST_MALFORMED;
      else if (!ended && c == CH_DOT) st = ST_NOT_INT;
      else st = ST_INT;
      expected_tokens.push_back(close_literal(st));
      return;
    end
    count_char();
    if (lit_phase == PH_ZERO) begin
      lit_phase = PH_RUN;
      if (c == CH_LO_X) begin
        lit_radix = RADIX_HEX;
      end else if (c == CH_LO_B || c == CH_UP_B) begin
        lit_radix = RADIX_BIN;
      end else if (c >= CH_0 && c <= CH_7) begin
        lit_radix = RADIX_OCT;
        lit_value = 64'(c - CH_0);
      end else begin
        lit_malformed = 1'b1;
      end
      return;
    end
    if (!lit_malformed) begin
      d = digit_value(c, lit_radix);
      if (d < 0) lit_malformed = 1'b1;
      else add_digit(d);
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function int draw_wait();
    if (steady_flow) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [7:0] random_non_alnum();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_alnum(c));
    return c;
  endfunction

  function automatic logic [7:0] random_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c));
    return c;
  endfunction

  function automatic logic [7:0] random_alnum();
    int k;
    k = $urandom_range(0, 61);
    if (k < 10) return 8'(CH_0 + k);
    if (k < 36) return 8'(CH_LO_A + k - 10);
    return 8'(CH_UP_A + k - 36);
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return 8'(CH_0 + v);
    return $urandom_range(0, 1) ? 8'(CH_LO_A + v - 10) : 8'(CH_UP_A + v - 10);
  endfunction

  task automatic send_char(logic [7:0] c, bit ended = 1'b0);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.char_in    <= c;
    in_if.text_ended <= ended;
    do @(posedge clk); while (!in_if.ready);
    advance_literal(c, ended);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // The character that rides with an end-of-text beat is ignored, so it is random.
  task automatic send_end_of_text();
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_terminator();
    case ($urandom_range(0, 5))
      0:       send_end_of_text();
      1:       send_char(CH_DOT);
      2:       send_char(8'($urandom_range(128, 255)));
      3:       send_char(CH_SPACE);
      default: send_char(random_non_alnum());
    endcase
  endtask

  task automatic send_number();
    radix_t r;
    int     n;
    int     v;
    bit     all_max;
    r       = radix_t'($urandom_range(0, 3));
    n       = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 6) : $urandom_range(0, 24);
    all_max = ($urandom_range(0, 3) == 0);
    case (r)
      RADIX_DEC: send_char(8'(CH_0 + $urandom_range(1, 9)));
      RADIX_OCT: send_char(CH_0);
      RADIX_HEX: begin
        send_char(CH_0);
        send_char(($urandom_range(0, 9) == 0) ? CH_UP_X : CH_LO_X);
      end
      default: begin
        send_char(CH_0);
        send_char($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
      end
    endcase
    for (int i = 0; i < n; i++) begin
      v = all_max ? max_digit(r) : $urandom_range(0, max_digit(r));
      // Now and then a stray letter or digit spoils the literal.
      if ($urandom_range(0, 39) == 0) send_char(random_alnum());
      else send_char(digit_char(v));
    end
    send_terminator();
  endtask

  task automatic send_random_token();
    int kind;
    kind = $urandom_range(0, 39);
    if (kind == 0) begin
      send_end_of_text();
    end else if (kind < 4) begin
      send_char(random_non_digit());
    end else if (kind < 6) begin
      send_char(8'(CH_0 + $urandom_range(0, 9)));
      repeat ($urandom_range(0, 6)) send_char(random_alnum());
      send_terminator();
    end else if (kind < 8) begin
      send_text(boundary_literals[$urandom_range(0, 7)]);
      send_terminator();
    end else if (kind == 8) begin
      // Long binary run: can wrap past 64 bits and saturate the length.
      send_char(CH_0);
      send_char($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
      repeat ($urandom_range(55, 70)) send_char(8'(CH_0 + $urandom_range(0, 1)));
      send_terminator();
    end else begin
      send_number();
    end
  endtask

  // --------------------------------------------------------------- checks

  function void report_mismatch(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("MISMATCH %s", msg);
  endfunction

  task automatic check_token();
    token_result_t want;
    bit            bad;
    checked_tokens++;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected result: status=%0d value=%h len=%0d",
                                out_if.status, out_if.value, out_if.token_length));
      return;
    end
    want = expected_tokens.pop_front();
    bad  = (out_if.status !== want.status) || (out_if.value !== want.value) ||
           (out_if.base_code !== want.base_code) || (out_if.is_long !== want.is_long) ||
           (out_if.token_length !== want.token_length) ||
           (out_if.overflowed !== want.overflowed);
    if (bad) begin
      report_mismatch($sformatf({"token %0d: expected status=%0d value=%h base=%0d long=%b",
                                 " len=%0d ovf=%b, got status=%0d value=%h base=%0d long=%b",
                                 " len=%0d ovf=%b"},
                                checked_tokens, want.status, want.value, want.base_code,
                                want.is_long, want.token_length, want.overflowed,
                                out_if.status, out_if.value, out_if.base_code,
                                out_if.is_long, out_if.token_length, out_if.overflowed));
    end
    if (want.status == ST_INT) int_tokens++;
    if (want.status == ST_MALFORMED) malformed_tokens++;
    if (want.overflowed) overflow_tokens++;
  endtask

  // Result side: a random stall before each beat, then take it and check it.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      check_token();
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_rejected_starts();
    send_end_of_text();
    send_char(CH_LO_A);
  endtask

  task automatic test_lone_zero();
    send_char(CH_0);
    send_char(8'h00);
  endtask

  task automatic test_radix_forms();
    send_text("0xfF");
    send_char(CH_SPACE);
    send_text("0B1");
    send_end_of_text();
  endtask

  task automatic test_dot_terminator();
    send_text("017.");
  endtask

  task automatic test_malformed_digits();
    send_text("08");
    send_char(CH_SPACE);
    send_text("12a");
    send_char(8'hFF);
  endtask

  task automatic test_empty_prefix();
    send_text("0b");
    send_end_of_text();
  endtask

  task automatic test_random_tokens();
    int first;
    first = chars_sent;
    while (chars_sent - first < RANDOM_CHARS) begin
      if ($urandom_range(0, 15) == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_random_token();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.char_in    <= '0;
    in_if.text_ended <= 1'b0;
    clear_literal();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_rejected_starts();
    test_lone_zero();
    test_radix_forms();
    test_dot_terminator();
    test_malformed_digits();
    test_empty_prefix();
    test_random_tokens();
    in_if.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters; checked %0d tokens, %0d integers, %0d malformed.",
             chars_sent, checked_tokens, int_tokens, malformed_tokens);
    $display("%0d literals overflowed; all four radixes, dot ends and end of text seen.",
             overflow_tokens);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
